// File: hdl/dqp_pkg.sv
// shared types and constants for the dns question parser
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package dqp_pkg;

    localparam int HDR_LEN  = 12;
    localparam int MIN_PKT  = 18;
    localparam logic [7:0] DOT_CHAR = 8'h2E;

    // record queue between parser and output stage
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_TRUNCATED = 2'd1,
        ERR_NAME_LONG = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LEN    = 3'd1,
        PH_BODY   = 3'd2,
        PH_TAIL   = 3'd3,
        PH_SKIP   = 3'd4
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  name_char;
        logic [15:0] query_id;
        logic [15:0] header_flags;
        logic [15:0] query_type;
        logic [15:0] query_class;
        logic [7:0]  name_length;
        err_t        error_code;
    } rec_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

// File: hdl/dqp_front.sv
// front end: accepts packet bytes, walks header, labels and type/class
// depends on dqp_pkg; pushes one record per byte at most into the queue
`timescale 1ns / 1ps
`default_nettype none

module dqp_front #(
    parameter int MAX_NAME_LEN = 255
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    input  wire logic [7:0]     in_byte,
    input  wire logic           in_last,
    input  wire dqp_pkg::q_stat_t q_stat,
    output logic                in_ready,
    output logic                push,
    output dqp_pkg::rec_t       push_rec
);

    localparam logic [9:0] MAX_LEN = 10'(MAX_NAME_LEN);

    logic [4:0]  byte_count_reg, byte_count_next;
    dqp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  label_rem_reg, label_rem_next;
    logic [8:0]  name_count_reg, name_count_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] flags_reg, flags_next;
    logic [31:0] type_class_reg, type_class_next;
    logic [2:0]  tail_count_reg, tail_count_next;

    logic        accept;
    logic        sep;
    logic [9:0]  len_sum;
    logic [7:0]  label_dec;
    logic        new_pkt;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign sep      = (name_count_reg != 9'd0);
    assign len_sum  = {1'b0, name_count_reg} + {9'd0, sep} + {2'd0, in_byte};
    assign label_dec = label_rem_reg - 8'd1;

    always_comb begin
        byte_count_next = byte_count_reg;
        phase_next      = phase_reg;
        label_rem_next  = label_rem_reg;
        name_count_next = name_count_reg;
        id_next         = id_reg;
        flags_next      = flags_reg;
        type_class_next = type_class_reg;
        tail_count_next = tail_count_reg;
        new_pkt         = 1'b0;
        push            = 1'b0;
        push_rec        = '0;

        if (accept) begin
            if (byte_count_reg != 5'd31) begin
                byte_count_next = byte_count_reg + 5'd1;
            end
            unique case (phase_reg)
                dqp_pkg::PH_HEADER: begin
                    if (byte_count_reg < 5'd2) begin
                        id_next = {id_reg[7:0], in_byte};
                    end else if (byte_count_reg < 5'd4) begin
                        flags_next = {flags_reg[7:0], in_byte};
                    end
                    if (in_last) begin
                        push                = 1'b1;
                        push_rec.kind       = dqp_pkg::KIND_ERROR;
                        push_rec.error_code = dqp_pkg::ERR_TRUNCATED;
                        new_pkt             = 1'b1;
                    end else if (byte_count_reg >= 5'(dqp_pkg::HDR_LEN - 1)) begin
                        phase_next = dqp_pkg::PH_LEN;
                    end
                end
                dqp_pkg::PH_LEN: begin
                    if (in_last) begin
                        push                = 1'b1;
                        push_rec.kind       = dqp_pkg::KIND_ERROR;
                        push_rec.error_code = dqp_pkg::ERR_TRUNCATED;
                        new_pkt             = 1'b1;
                    end else if (in_byte == 8'd0) begin
                        phase_next      = dqp_pkg::PH_TAIL;
                        tail_count_next = 3'd0;
                    end else if (len_sum > MAX_LEN) begin
                        push                = 1'b1;
                        push_rec.kind       = dqp_pkg::KIND_ERROR;
                        push_rec.error_code = dqp_pkg::ERR_NAME_LONG;
                        phase_next          = dqp_pkg::PH_SKIP;
                    end else begin
                        label_rem_next = in_byte;
                        phase_next     = dqp_pkg::PH_BODY;
                        if (sep) begin
                            name_count_next    = name_count_reg + 9'd1;
                            push               = 1'b1;
                            push_rec.kind      = dqp_pkg::KIND_CHAR;
                            push_rec.name_char = dqp_pkg::DOT_CHAR;
                        end
                    end
                end
                dqp_pkg::PH_BODY: begin
                    if (in_last) begin
                        push                = 1'b1;
                        push_rec.kind       = dqp_pkg::KIND_ERROR;
                        push_rec.error_code = dqp_pkg::ERR_TRUNCATED;
                        new_pkt             = 1'b1;
                    end else begin
                        name_count_next    = name_count_reg + 9'd1;
                        label_rem_next     = label_dec;
                        if (label_dec == 8'd0) begin
                            phase_next = dqp_pkg::PH_LEN;
                        end
                        push               = 1'b1;
                        push_rec.kind      = dqp_pkg::KIND_CHAR;
                        push_rec.name_char = in_byte;
                    end
                end
                dqp_pkg::PH_TAIL: begin
                    type_class_next = {type_class_reg[23:0], in_byte};
                    if (tail_count_reg < 3'd3) begin
                        tail_count_next = tail_count_reg + 3'd1;
                        if (in_last) begin
                            push                = 1'b1;
                            push_rec.kind       = dqp_pkg::KIND_ERROR;
                            push_rec.error_code = dqp_pkg::ERR_TRUNCATED;
                            new_pkt             = 1'b1;
                        end
                    end else if (in_last &&
                                 byte_count_reg < 5'(dqp_pkg::MIN_PKT - 1)) begin
                        push                = 1'b1;
                        push_rec.kind       = dqp_pkg::KIND_ERROR;
                        push_rec.error_code = dqp_pkg::ERR_TRUNCATED;
                        new_pkt             = 1'b1;
                    end else begin
                        push                  = 1'b1;
                        push_rec.kind         = dqp_pkg::KIND_DONE;
                        push_rec.query_id     = id_reg;
                        push_rec.header_flags = flags_reg;
                        push_rec.query_type   = type_class_next[31:16];
                        push_rec.query_class  = type_class_next[15:0];
                        push_rec.name_length  = name_count_reg[7:0];
                        if (in_last) begin
                            new_pkt = 1'b1;
                        end else begin
                            phase_next = dqp_pkg::PH_SKIP;
                        end
                    end
                end
                default: begin
                    if (in_last) begin
                        new_pkt = 1'b1;
                    end
                end
            endcase

            if (new_pkt) begin
                byte_count_next = 5'd0;
                phase_next      = dqp_pkg::PH_HEADER;
                label_rem_next  = 8'd0;
                name_count_next = 9'd0;
                tail_count_next = 3'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= 5'd0;
            phase_reg      <= dqp_pkg::PH_HEADER;
            label_rem_reg  <= 8'd0;
            name_count_reg <= 9'd0;
            id_reg         <= 16'd0;
            flags_reg      <= 16'd0;
            type_class_reg <= 32'd0;
            tail_count_reg <= 3'd0;
        end else begin
            byte_count_reg <= byte_count_next;
            phase_reg      <= phase_next;
            label_rem_reg  <= label_rem_next;
            name_count_reg <= name_count_next;
            id_reg         <= id_next;
            flags_reg      <= flags_next;
            type_class_reg <= type_class_next;
            tail_count_reg <= tail_count_next;
        end
    end

    // the name never grows past the limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, name_count_reg} <= MAX_LEN)
        else $error("name count beyond limit");

    // a body phase always has label bytes left
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == dqp_pkg::PH_BODY |-> label_rem_reg != 8'd0)
        else $error("body phase with empty label");

    // records are only produced for accepted bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> accept)
        else $error("record without an accepted byte");

endmodule

`default_nettype wire

// File: hdl/dqp_queue.sv
// short record queue between the parser front end and the output stage
// depends on dqp_pkg for the record type and depth
`timescale 1ns / 1ps
`default_nettype none

module dqp_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire dqp_pkg::rec_t  push_rec,
    input  wire logic           pop,
    output dqp_pkg::rec_t       head_rec,
    output dqp_pkg::q_stat_t    q_stat
);

    localparam logic [dqp_pkg::Q_AW-1:0] PTR_STEP = {{(dqp_pkg::Q_AW - 1){1'b0}}, 1'b1};
    localparam logic [dqp_pkg::Q_AW:0]   CNT_STEP = {{dqp_pkg::Q_AW{1'b0}}, 1'b1};

    dqp_pkg::rec_t mem_reg [dqp_pkg::Q_DEPTH];

    logic [dqp_pkg::Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dqp_pkg::Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dqp_pkg::Q_AW:0]   count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_STEP : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_STEP : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_STEP;
        end else if (pop && !push) begin
            count_next = count_reg - CNT_STEP;
        end
    end

    assign q_stat.full  = (count_reg == (dqp_pkg::Q_AW + 1)'(dqp_pkg::Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head_rec     = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("push into full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // pointers and count stay consistent
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[dqp_pkg::Q_AW-1:0])
        else $error("queue pointers out of step");

endmodule

`default_nettype wire

// File: hdl/dqp_back.sv
// back end: output register fed from the record queue
// depends on dqp_pkg; packs a record onto the result stream
`timescale 1ns / 1ps
`default_nettype none

module dqp_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire dqp_pkg::q_stat_t q_stat,
    input  wire dqp_pkg::rec_t  head_rec,
    output logic                pop,
    input  wire logic           out_ready,
    output logic                out_valid,
    output logic [87:0]         out_data,
    output logic [1:0]          out_user
);

    logic          valid_reg, valid_next;
    dqp_pkg::rec_t rec_reg;

    assign pop        = !q_stat.empty && (!valid_reg || out_ready);
    assign valid_next = pop ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            rec_reg <= head_rec;
        end
    end

    assign out_valid = valid_reg;
    assign out_user  = rec_reg.kind;
    assign out_data  = {6'd0, rec_reg.error_code, rec_reg.name_length,
                        rec_reg.query_class, rec_reg.query_type,
                        rec_reg.header_flags, rec_reg.query_id, rec_reg.name_char};

endmodule

`default_nettype wire

// File: hdl/dns_question_parser_unit.sv
// top level of the dns question parser: front end, record queue, output stage
// depends on dqp_pkg, dqp_front, dqp_queue and dqp_back
//
//  port group  dir  payload
//  s_*         in   tdata[7:0] data_byte, tlast last_byte
//  m_*         out  tdata name_char..error_code (82 bits in 88), tuser kind
//
// one packet byte per cycle is taken back to back while the record queue is not full;
// the parser updates only small counters per byte in the front end.
// each result is registered in the record queue and then in the output register.
// a stalled m_tready fills the 4-entry record queue, then s_tready drops.
// aresetn is synchronous and active low; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module dns_question_parser_unit #(
    parameter int MAX_NAME_LEN = 255
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] name_char, [23:8] query_id, [39:24] header_flags,
    // [55:40] query_type, [71:56] query_class, [79:72] name_length,
    // [81:80] error_code, [87:82] zero
    output logic [87:0]      m_tdata,
    output logic [1:0]       m_tuser    // [1:0] kind
);

    logic             push;
    logic             pop;
    dqp_pkg::rec_t    push_rec;
    dqp_pkg::rec_t    head_rec;
    dqp_pkg::q_stat_t q_stat;

    dqp_front #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_stat   (q_stat),
        .in_ready (s_tready),
        .push     (push),
        .push_rec (push_rec)
    );

    dqp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .q_stat   (q_stat)
    );

    dqp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_stat    (q_stat),
        .head_rec  (head_rec),
        .pop       (pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule

`default_nettype wire

// File: dv/dns_question_parser_unit_tb.sv
// self-checking testbench for dns_question_parser_unit: byte stream in, name/record stream out
// depends on dqp_pkg and the dns_question_parser_unit rtl; builds packets, predicts records, checks
`timescale 1ns / 1ps

module dns_question_parser_unit_tb;

    localparam int NAME_LIMIT   = 255;
    localparam int RAND_BYTES   = 900;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_BYTE = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int GAP_PCT      = 37;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } feed_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;

    dns_question_parser_unit #(
        .MAX_NAME_LEN(NAME_LIMIT)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    feed_item_t    byte_feed[$];
    logic [7:0]    pkt_buf[$];
    dqp_pkg::rec_t pending_recs[$];
    int            err_cnt = 0;
    int            bytes_sent = 0;
    int            bytes_taken = 0;

    // parser state mirror
    logic [4:0]       p_cnt;
    dqp_pkg::phase_t  p_ph;
    logic [7:0]       p_rem;
    logic [8:0]       p_name;
    logic [15:0]      p_id;
    logic [15:0]      p_flags;
    logic [31:0]      p_tc;
    logic [2:0]       p_tail;

    task automatic start_packet();
        p_cnt  = '0;
        p_ph   = dqp_pkg::PH_HEADER;
        p_rem  = '0;
        p_name = '0;
        p_tail = '0;
    endtask

    task automatic raise_error(input dqp_pkg::err_t code, input logic fin);
        dqp_pkg::rec_t r;
        r = '0;
        r.kind = dqp_pkg::KIND_ERROR;
        r.error_code = code;
        pending_recs.push_back(r);
        if (fin) begin
            start_packet();
        end else begin
            p_ph = dqp_pkg::PH_SKIP;
        end
    endtask

    task automatic push_char(input logic [7:0] c);
        dqp_pkg::rec_t r;
        r = '0;
        r.kind = dqp_pkg::KIND_CHAR;
        r.name_char = c;
        pending_recs.push_back(r);
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic fin);
        dqp_pkg::rec_t r;
        int   idx;
        int   sep;
        idx = int'(p_cnt);
        if (p_cnt < 5'd31) p_cnt = p_cnt + 5'd1;
        case (p_ph)
            dqp_pkg::PH_HEADER: begin
                if (idx < 2) p_id = {p_id[7:0], b};
                else if (idx < 4) p_flags = {p_flags[7:0], b};
                if (fin) begin
                    raise_error(dqp_pkg::ERR_TRUNCATED, 1'b1);
                end else if (idx + 1 >= dqp_pkg::HDR_LEN) begin
                    p_ph = dqp_pkg::PH_LEN;
                end
            end
            dqp_pkg::PH_LEN: begin
                if (fin) begin
                    raise_error(dqp_pkg::ERR_TRUNCATED, 1'b1);
                end else if (b == 8'd0) begin
                    p_ph = dqp_pkg::PH_TAIL;
                    p_tail = '0;
                end else begin
                    sep = (p_name != 9'd0) ? 1 : 0;
                    if (int'(p_name) + sep + int'(b) > NAME_LIMIT) begin
                        raise_error(dqp_pkg::ERR_NAME_LONG, 1'b0);
                    end else begin
                        p_rem = b;
                        p_ph = dqp_pkg::PH_BODY;
                        if (sep != 0) begin
                            p_name = p_name + 9'd1;
                            push_char(dqp_pkg::DOT_CHAR);
                        end
                    end
                end
            end
            dqp_pkg::PH_BODY: begin
                if (fin) begin
                    raise_error(dqp_pkg::ERR_TRUNCATED, 1'b1);
                end else begin
                    p_name = p_name + 9'd1;
                    p_rem = p_rem - 8'd1;
                    if (p_rem == 8'd0) p_ph = dqp_pkg::PH_LEN;
                    push_char(b);
                end
            end
            dqp_pkg::PH_TAIL: begin
                p_tc = {p_tc[23:0], b};
                if (p_tail < 3'd3) begin
                    p_tail = p_tail + 3'd1;
                    if (fin) raise_error(dqp_pkg::ERR_TRUNCATED, 1'b1);
                end else if (fin && idx + 1 < dqp_pkg::MIN_PKT) begin
                    raise_error(dqp_pkg::ERR_TRUNCATED, 1'b1);
                end else begin
                    r = '0;
                    r.kind = dqp_pkg::KIND_DONE;
                    r.query_id = p_id;
                    r.header_flags = p_flags;
                    r.query_type = p_tc[31:16];
                    r.query_class = p_tc[15:0];
                    r.name_length = p_name[7:0];
                    r.error_code = dqp_pkg::ERR_NONE;
                    pending_recs.push_back(r);
                    if (fin) begin
                        start_packet();
                    end else begin
                        p_ph = dqp_pkg::PH_SKIP;
                    end
                end
            end
            default: begin
                if (fin) start_packet();
            end
        endcase
    endtask

    // packet building

    task automatic add_byte(input logic [7:0] b);
        pkt_buf.push_back(b);
    endtask

    task automatic add_header(input logic [15:0] id, input logic [15:0] flags);
        add_byte(id[15:8]);
        add_byte(id[7:0]);
        add_byte(flags[15:8]);
        add_byte(flags[7:0]);
        repeat (dqp_pkg::HDR_LEN - 4) add_byte(8'($urandom));
    endtask

    task automatic add_label(input int len);
        add_byte(8'(len));
        repeat (len) add_byte(8'($urandom));
    endtask

    task automatic add_tail(input logic [15:0] qt, input logic [15:0] qc);
        add_byte(qt[15:8]);
        add_byte(qt[7:0]);
        add_byte(qc[15:8]);
        add_byte(qc[7:0]);
    endtask

    task automatic flush_packet();
        feed_item_t it;
        foreach (pkt_buf[i]) begin
            it.data = pkt_buf[i];
            it.fin = (i == pkt_buf.size() - 1);
            byte_feed.push_back(it);
        end
        pkt_buf.delete();
    endtask

    task automatic add_good_body();
        int nlab;
        nlab = $urandom_range(0, 4);
        add_header(16'($urandom), 16'($urandom));
        repeat (nlab) add_label($urandom_range(1, ($urandom_range(0, 9) == 0) ? 80 : 10));
        add_byte(8'd0);
        add_tail(16'($urandom), 16'($urandom));
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
    endtask

    // labels until the name would pass the limit, sometimes landing on it exactly
    task automatic add_long_name();
        int nc;
        int sep;
        int room;
        int len;
        bit stop;
        nc = 0;
        stop = 1'b0;
        add_header(16'($urandom), 16'($urandom));
        while (!stop) begin
            sep = (nc != 0) ? 1 : 0;
            room = NAME_LIMIT - nc - sep;
            if (room < 1) begin
                if ($urandom_range(0, 1) == 1) begin
                    add_byte(8'd0);
                    add_tail(16'($urandom), 16'($urandom));
                end else begin
                    add_byte(8'($urandom_range(1, 255)));
                end
                stop = 1'b1;
            end else begin
                len = ($urandom_range(0, 3) == 0) ? room : $urandom_range(1, 255);
                if (len > 255) len = $urandom_range(1, 255);
                if (len > room) begin
                    add_byte(8'(len));
                    stop = 1'b1;
                end else begin
                    add_label(len);
                    nc = nc + sep + len;
                end
            end
        end
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
    endtask

    task automatic build_stimulus();
        int kind_sel;
        int n;
        // complete question with one label, field extremes
        add_header(16'hFFFF, 16'h0000);
        add_label(1);
        add_byte(8'd0);
        add_tail(16'hFFFF, 16'h0000);
        flush_packet();
        // root name ending on the 17th byte: too short
        add_header(16'h0000, 16'hFFFF);
        add_byte(8'd0);
        add_tail(16'h0000, 16'hFFFF);
        flush_packet();
        // root name at exactly the minimum size
        add_header(16'h8001, 16'h7FFE);
        add_byte(8'd0);
        add_tail(16'h0001, 16'h8000);
        add_byte(8'hFF);
        flush_packet();
        // one-byte packet, then early end inside the header
        add_byte(8'hA5);
        flush_packet();
        repeat (5) add_byte(8'($urandom));
        flush_packet();
        // early end on a length byte, in a label body, inside the tail
        add_header(16'($urandom), 16'($urandom));
        add_label(2);
        add_byte(8'd3);
        flush_packet();
        add_header(16'($urandom), 16'($urandom));
        add_label(3);
        pkt_buf = pkt_buf[0:pkt_buf.size() - 2];
        flush_packet();
        add_header(16'($urandom), 16'($urandom));
        add_label(1);
        add_byte(8'd0);
        add_byte(8'h12);
        add_byte(8'h34);
        flush_packet();

        add_long_name();
        flush_packet();
        while (byte_feed.size() < RAND_BYTES) begin
            kind_sel = $urandom_range(0, 99);
            if (kind_sel < 70) begin
                add_good_body();
            end else if (kind_sel < 86) begin
                add_good_body();
                n = $urandom_range(1, pkt_buf.size());
                pkt_buf = pkt_buf[0:n - 1];
            end else if (kind_sel < 92) begin
                add_long_name();
            end else begin
                repeat ($urandom_range(1, 40)) add_byte(8'($urandom));
            end
            flush_packet();
        end
    endtask

    // sender

    feed_item_t cur;
    bit         send_gap;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'd0;
            s_tlast <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, s_tlast);
                bytes_taken = bytes_taken + 1;
            end
            if (!s_tvalid || s_tready) begin
                send_gap = ($urandom_range(0, 99) < GAP_PCT)
                           && !(bytes_sent >= 450 && bytes_sent < 650);
                if (byte_feed.size() != 0 && !send_gap) begin
                    cur = byte_feed.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= cur.data;
                    s_tlast <= cur.fin;
                    bytes_sent = bytes_sent + 1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off that backs the block up into its input

    int rx_cyc = 0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cyc = rx_cyc + 1;
            if (hold_cnt != 0) begin
                hold_cnt = hold_cnt - 1;
                m_tready <= 1'b0;
            end else if (!hold_done && bytes_taken >= HOLD_AT_BYTE) begin
                hold_done = 1'b1;
                hold_cnt = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (rx_cyc >= 1200 && rx_cyc < 1500) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= GAP_PCT);
            end
        end
    end

    // result checking

    task automatic check_field(input string fname, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", fname, exp_v, act_v);
            err_cnt = err_cnt + 1;
        end
    endtask

    dqp_pkg::rec_t want;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_recs.size() == 0) begin
                $error("unexpected record: kind %0d tdata %0h", m_tuser, m_tdata);
                err_cnt = err_cnt + 1;
            end else begin
                want = pending_recs.pop_front();
                check_field("kind", 16'(want.kind), 16'(m_tuser));
                check_field("name_char", 16'(want.name_char), 16'(m_tdata[7:0]));
                check_field("query_id", want.query_id, m_tdata[23:8]);
                check_field("header_flags", want.header_flags, m_tdata[39:24]);
                check_field("query_type", want.query_type, m_tdata[55:40]);
                check_field("query_class", want.query_class, m_tdata[71:56]);
                check_field("name_length", 16'(want.name_length), 16'(m_tdata[79:72]));
                check_field("error_code", 16'(want.error_code), 16'(m_tdata[81:80]));
                check_field("pad", 16'd0, 16'(m_tdata[87:82]));
            end
        end
    end

    // watchdog on cycles without any request moving

    int stall_cnt = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cnt = 0;
            end else begin
                stall_cnt = stall_cnt + 1;
            end
            if (stall_cnt >= STALL_LIMIT) begin
                $display("dns_question_parser_unit_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        p_id = '0;
        p_flags = '0;
        p_tc = '0;
        start_packet();
        build_stimulus();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (byte_feed.size() != 0 || s_tvalid || pending_recs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_cnt == 0 && pending_recs.size() == 0) begin
            $display("dns_question_parser_unit_tb: clean");
        end else begin
            $display("dns_question_parser_unit_tb: errors");
        end
        $finish;
    end

endmodule
